### sv/cst_pkg.sv
// Package for the counting semaphore table: command and status codes,
// controller-to-datapath command/status structs. No dependencies.
package cst_pkg;

    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 3;
    localparam int SEM_ID_BITS = 4;
    localparam int COUNT_BITS  = 8;
    localparam int TID_BITS    = 8;
    localparam int NAME_PORT_BITS = 16;
    localparam int SCOUNT_BITS = 16;
    localparam int OPEN_BITS   = 8;

    localparam logic [CMD_BITS-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_OPEN    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLOSE   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_WAIT    = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_SIGNAL  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_INUSE    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_QFULL    = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction, reset scan
        logic scan_step;  // compare current scan slot, advance
        logic rd_slot;    // select target slot and whether it is valid
        logic rd_queue;   // read slot record of target slot
        logic commit;     // apply update, form result
    } cst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic needs_scan;
    } cst_stat_t;

endpackage

### sv/cst_ctrl.sv
// Controller FSM of the counting semaphore table.
// Depends on cst_pkg.
module cst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output cst_pkg::cst_cmd_t   cmd_o,
    input  cst_pkg::cst_stat_t  stat_i
);
    import cst_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_READ   = 6'b000100,
        S_QREAD  = 6'b001000,
        S_COMMIT = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd_o = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_o.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat_i.needs_scan && !stat_i.scan_done)
                    cmd_o.scan_step = 1'b1;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd_o.rd_slot = 1'b1;
                state_next = S_QREAD;
            end
            S_QREAD:
            begin
                cmd_o.rd_queue = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd_o.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/cst_datapath.sv
// Datapath of the counting semaphore table: slot records, name scan,
// waiter memory and result registers. Depends on cst_pkg.
module cst_datapath #(
    parameter int NUM_SEMAPHORES = 16,
    parameter int QUEUE_DEPTH    = 16,
    parameter int NAME_BITS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cst_pkg::cst_cmd_t                   cmd_i,
    output cst_pkg::cst_stat_t                  stat_o,
    input  logic [cst_pkg::CMD_BITS-1:0]        cmd,
    input  logic [cst_pkg::NAME_PORT_BITS-1:0]  sem_key,
    input  logic [cst_pkg::SEM_ID_BITS-1:0]     sem_id,
    input  logic [cst_pkg::COUNT_BITS-1:0]      start_count,
    input  logic [cst_pkg::TID_BITS-1:0]        thread_id,
    output logic [cst_pkg::STATUS_BITS-1:0]     status,
    output logic [cst_pkg::SEM_ID_BITS-1:0]     returned_id,
    output logic                                must_block,
    output logic                                wake_valid,
    output logic [cst_pkg::TID_BITS-1:0]        wake_thread
);
    import cst_pkg::*;

    localparam int SB = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FB = $clog2(QUEUE_DEPTH + 1);
    localparam int CB = $clog2(NUM_SEMAPHORES + 1);
    localparam int PW = QB + FB + 1;
    localparam int MEM_DEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
    localparam int NB = (NAME_BITS < NAME_PORT_BITS) ? NAME_BITS : NAME_PORT_BITS;
    localparam logic signed [SCOUNT_BITS-1:0] CNT_MAX = 16'sh7fff;

    logic [NUM_SEMAPHORES-1:0] valid_reg;
    logic [NB-1:0]             name_mem   [NUM_SEMAPHORES];
    logic signed [SCOUNT_BITS-1:0] count_mem [NUM_SEMAPHORES];
    logic [OPEN_BITS-1:0]      open_mem   [NUM_SEMAPHORES];
    logic [QB-1:0]             head_mem   [NUM_SEMAPHORES];
    logic [FB-1:0]             fill_mem   [NUM_SEMAPHORES];
    logic [TID_BITS-1:0]       waiter_mem [MEM_DEPTH];

    // captured transaction
    logic [CMD_BITS-1:0] cmd_reg;
    logic [NB-1:0]       name_reg;
    logic [SEM_ID_BITS-1:0] id_reg;
    logic [COUNT_BITS-1:0]  init_reg;
    logic [TID_BITS-1:0]    tid_reg;

    // scan state
    logic [CB-1:0] scan_reg;
    logic          found_reg;
    logic [SB-1:0] found_idx_reg;
    logic          free_reg;
    logic [SB-1:0] free_idx_reg;

    // slot record read
    logic [SB-1:0] tgt_reg;
    logic          tgt_ok_reg;
    logic signed [SCOUNT_BITS-1:0] cnt_rd_reg;
    logic [OPEN_BITS-1:0] open_rd_reg;
    logic [QB-1:0]        head_rd_reg;
    logic [FB-1:0]        fill_rd_reg;
    logic [TID_BITS-1:0]  wait_rd_reg;

    logic is_name_cmd;
    assign is_name_cmd = (cmd_reg == CMD_CREATE) || (cmd_reg == CMD_DESTROY)
                      || (cmd_reg == CMD_OPEN);
    assign stat_o.needs_scan = is_name_cmd;
    assign stat_o.scan_done  = (scan_reg == CB'(NUM_SEMAPHORES)) || found_reg;

    logic [SB-1:0] scan_idx;
    assign scan_idx = scan_reg[SB-1:0];

    // id path: sem_id must address an existing, valid slot
    logic          id_in_range;
    logic [SB-1:0] id_idx;
    always_comb
    begin
        id_in_range = ({{(32-SEM_ID_BITS){1'b0}}, id_reg} < NUM_SEMAPHORES);
        id_idx = SB'({{(32-SEM_ID_BITS){1'b0}}, id_reg});
    end

    // head + fill stays below twice the depth, so one subtract wraps it
    logic [QB-1:0] wr_pos;
    logic [PW-1:0] pos_sum;
    always_comb
    begin
        pos_sum = {{(FB+1){1'b0}}, head_rd_reg} + {{(QB+1){1'b0}}, fill_rd_reg};
        if (pos_sum >= PW'(QUEUE_DEPTH))
            wr_pos = QB'(pos_sum - PW'(QUEUE_DEPTH));
        else
            wr_pos = QB'(pos_sum);
    end

    // read address uses the live head so the waiter is ready at commit
    logic [SB+QB-1:0] waddr, raddr;
    always_comb
    begin
        waddr = (SB+QB)'(tgt_reg * QUEUE_DEPTH) + (SB+QB)'(wr_pos);
        raddr = (SB+QB)'(tgt_reg * QUEUE_DEPTH) + (SB+QB)'(head_mem[tgt_reg]);
    end

    logic [QB-1:0] head_inc;
    always_comb
    begin
        if (QUEUE_DEPTH > 1 && head_rd_reg != QB'(QUEUE_DEPTH - 1))
            head_inc = head_rd_reg + 1'b1;
        else
            head_inc = '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            scan_reg  <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_i.load)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (cmd_i.scan_step)
            begin
                if (valid_reg[scan_idx] && name_mem[scan_idx] == name_reg)
                    found_reg <= 1'b1;
                if (!valid_reg[scan_idx] && !free_reg)
                    free_reg <= 1'b1;
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd_i.commit && tgt_ok_reg)
            begin
                if (cmd_reg == CMD_CREATE && !found_reg)
                    valid_reg[tgt_reg] <= 1'b1;
                if (cmd_reg == CMD_DESTROY && fill_rd_reg == '0 && open_rd_reg == '0)
                    valid_reg[tgt_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            cmd_reg  <= cmd;
            name_reg <= sem_key[NB-1:0];
            id_reg   <= sem_id;
            init_reg <= start_count;
            tid_reg  <= thread_id;
        end
        if (cmd_i.scan_step)
        begin
            if (valid_reg[scan_idx] && name_mem[scan_idx] == name_reg)
                found_idx_reg <= scan_idx;
            if (!valid_reg[scan_idx] && !free_reg)
                free_idx_reg <= scan_idx;
        end
        if (cmd_i.rd_slot)
        begin
            case (cmd_reg)
                CMD_CREATE:
                begin
                    tgt_reg    <= free_idx_reg;
                    tgt_ok_reg <= free_reg;
                end
                CMD_DESTROY, CMD_OPEN:
                begin
                    tgt_reg    <= found_idx_reg;
                    tgt_ok_reg <= found_reg;
                end
                CMD_CLOSE, CMD_WAIT, CMD_SIGNAL:
                begin
                    tgt_reg    <= id_idx;
                    tgt_ok_reg <= id_in_range && valid_reg[id_idx];
                end
                default:
                begin
                    tgt_reg    <= '0;
                    tgt_ok_reg <= 1'b0;
                end
            endcase
        end
        if (cmd_i.rd_queue)
        begin
            cnt_rd_reg  <= count_mem[tgt_reg];
            open_rd_reg <= open_mem[tgt_reg];
            head_rd_reg <= head_mem[tgt_reg];
            fill_rd_reg <= fill_mem[tgt_reg];
        end
        if (cmd_i.commit)
        begin
            status      <= ST_OK;
            returned_id <= '0;
            must_block  <= 1'b0;
            wake_valid  <= 1'b0;
            wake_thread <= '0;
            case (cmd_reg)
                CMD_CREATE:
                begin
                    if (found_reg)
                        status <= ST_DUP;
                    else if (!tgt_ok_reg)
                        status <= ST_FULL;
                    else
                    begin
                        name_mem[tgt_reg]  <= name_reg;
                        count_mem[tgt_reg] <= SCOUNT_BITS'(init_reg);
                        open_mem[tgt_reg]  <= '0;
                        head_mem[tgt_reg]  <= '0;
                        fill_mem[tgt_reg]  <= '0;
                        returned_id <= SEM_ID_BITS'(tgt_reg);
                    end
                end
                CMD_DESTROY:
                begin
                    if (!tgt_ok_reg)
                        status <= ST_NOTFOUND;
                    else if (fill_rd_reg != '0 || open_rd_reg != '0)
                        status <= ST_INUSE;
                end
                CMD_OPEN:
                begin
                    if (!tgt_ok_reg)
                        status <= ST_NOTFOUND;
                    else
                    begin
                        if (open_rd_reg != '1)
                            open_mem[tgt_reg] <= open_rd_reg + 1'b1;
                        returned_id <= SEM_ID_BITS'(tgt_reg);
                    end
                end
                CMD_CLOSE:
                begin
                    if (!tgt_ok_reg)
                        status <= ST_NOTFOUND;
                    else if (open_rd_reg != '0)
                        open_mem[tgt_reg] <= open_rd_reg - 1'b1;
                end
                CMD_WAIT:
                begin
                    if (!tgt_ok_reg)
                        status <= ST_NOTFOUND;
                    else if (cnt_rd_reg <= 0)
                    begin
                        if (fill_rd_reg >= FB'(QUEUE_DEPTH))
                            status <= ST_QFULL;
                        else
                        begin
                            waiter_mem[waddr]  <= tid_reg;
                            fill_mem[tgt_reg]  <= fill_rd_reg + 1'b1;
                            count_mem[tgt_reg] <= cnt_rd_reg - 1'b1;
                            must_block <= 1'b1;
                        end
                    end
                    else
                        count_mem[tgt_reg] <= cnt_rd_reg - 1'b1;
                end
                CMD_SIGNAL:
                begin
                    if (!tgt_ok_reg)
                        status <= ST_NOTFOUND;
                    else
                    begin
                        if (cnt_rd_reg != CNT_MAX)
                            count_mem[tgt_reg] <= cnt_rd_reg + 1'b1;
                        if (fill_rd_reg != '0)
                        begin
                            wake_valid  <= 1'b1;
                            wake_thread <= wait_rd_reg;
                            head_mem[tgt_reg] <= head_inc;
                            fill_mem[tgt_reg] <= fill_rd_reg - 1'b1;
                        end
                    end
                end
                default: status <= ST_NOTFOUND;
            endcase
        end
    end

    // registered waiter read at the head position
    always_ff @(posedge clk)
    begin
        wait_rd_reg <= waiter_mem[raddr];
    end

endmodule

### sv/counting_semaphore_table.sv
// Top level of the counting semaphore table: controller plus datapath.
// Depends on cst_pkg, cst_ctrl, cst_datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  input   | in_valid / in_ready     | cmd, sem_key, sem_id, start_count, thread_id
//  output  | out_valid / out_ready   | status, returned_id, must_block, wake_valid,
//          |                         | wake_thread
//
// One transaction at a time. Create, destroy and open scan the slots with one
// name comparator, one slot per cycle, stopping at a match; then every command
// goes through the slot select, slot read and commit steps to the result.
// Input is taken again in the cycle after the result leaves.
// Reset clears the slot valid bits and scan flags only; no clearing pass.
// The result is held until out_ready; no new input is taken meanwhile.
module counting_semaphore_table #(
    parameter int NUM_SEMAPHORES = 16,
    parameter int QUEUE_DEPTH    = 16,
    parameter int NAME_BITS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cst_pkg::CMD_BITS-1:0]        cmd,
    input  logic [cst_pkg::NAME_PORT_BITS-1:0]  sem_key,
    input  logic [cst_pkg::SEM_ID_BITS-1:0]     sem_id,
    input  logic [cst_pkg::COUNT_BITS-1:0]      start_count,
    input  logic [cst_pkg::TID_BITS-1:0]        thread_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cst_pkg::STATUS_BITS-1:0]     status,
    output logic [cst_pkg::SEM_ID_BITS-1:0]     returned_id,
    output logic                                must_block,
    output logic                                wake_valid,
    output logic [cst_pkg::TID_BITS-1:0]        wake_thread
);
    import cst_pkg::*;

    cst_cmd_t  dp_cmd;
    cst_stat_t dp_stat;

    cst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd_o     (dp_cmd),
        .stat_i    (dp_stat)
    );

    cst_datapath #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .NAME_BITS      (NAME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_i         (dp_cmd),
        .stat_o        (dp_stat),
        .cmd           (cmd),
        .sem_key       (sem_key),
        .sem_id        (sem_id),
        .start_count   (start_count),
        .thread_id     (thread_id),
        .status        (status),
        .returned_id   (returned_id),
        .must_block    (must_block),
        .wake_valid    (wake_valid),
        .wake_thread   (wake_thread)
    );

endmodule
